// ===== src/dfas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfas_pkg;

    // Store geometry.
    localparam int MAX_PIXELS = 262144;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int WORD_W     = 32;

    // Field widths.
    localparam int IDX_W   = 18;
    localparam int PIX_W   = 16;
    localparam int MASK_W  = 24;
    localparam int DIFF_W  = 25;
    localparam int COUNT_W = 16;
    localparam int FP_W    = 19;

    // Largest usable frame size: the store depth or the index span.
    localparam int SIZE_CAP_INT = (MAX_PIXELS < 262144) ? MAX_PIXELS : 262144;
    localparam logic [FP_W-1:0] SIZE_CAP = FP_W'(SIZE_CAP_INT);
    localparam logic [FP_W-1:0] FRAME_PIXELS_RESET = FP_W'(262144);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Lower bound of the subtracted result, signed Q.8.
    localparam logic signed [33:0] DIFF_MIN = -34'sd16777215;

    // Mean division: dividend is the 32-bit sum with 8 fraction bits appended.
    localparam int DVD_W     = WORD_W + 8;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Action codes.
    localparam logic [2:0] ACT_PIXEL  = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_FINISH = 3'd2;
    localparam logic [2:0] ACT_LOAD   = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_DIFF    = 2'd0;
    localparam logic [1:0] KIND_COLLECT = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // Register byte addresses.
    localparam logic [2:0] REG_FRAME_PIXELS = 3'd0;

endpackage

`default_nettype wire

// ===== src/dfas_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/dark_frame_average_subtract.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Dark-frame averaging and subtraction over a per-pixel store of 32-bit words.
// Input channel (in_valid/in_stall) carries one action per transaction: pixel,
// start collection, finish collection, load mask element or read mask element.
// Output channel (out_valid/out_stall) carries at most one result per pixel or
// read transaction; start, finish, load and out-of-frame actions give none.
// A pixel or read is taken in the idle state, which reads the store, and is
// finished in the execute state, which updates the word and loads the output
// register; the next transaction waits until it is through, because of the
// read-modify-write on the single store memory. Loads and ignored actions are
// done in the idle state. Start clears all MAX_PIXELS words, one per cycle.
// Finish while collecting, with a nonzero frame count, walks every word through
// a bit-serial divider: read, load, divide, write back. After reset the same
// clearing pass runs before the first input transaction is taken.
// The output register holds a result while out_stall is high; one more pixel or
// read transaction is taken meanwhile and then waits until the register drains.
// frame_pixels is written through the APB port at byte address 0.
module dark_frame_average_subtract
    import dfas_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    // input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [2:0]          action,
    input  wire logic [IDX_W-1:0]    pixel_index,
    input  wire logic [PIX_W-1:0]    pixel_value,
    input  wire logic [MASK_W-1:0]   mask_value,
    // output channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               result_kind,
    output logic [IDX_W-1:0]         result_index,
    output logic signed [DIFF_W-1:0] difference,
    output logic [COUNT_W-1:0]       frame_count,
    output logic [WORD_W-1:0]        stored_value
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_CLEAR    = 3'd2;
    localparam logic [2:0] ST_WALK_RD  = 3'd3;
    localparam logic [2:0] ST_WALK_LD  = 3'd4;
    localparam logic [2:0] ST_WALK_DIV = 3'd5;
    localparam logic [2:0] ST_WALK_WR  = 3'd6;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

    logic [2:0]           state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic [COUNT_W-1:0]   frames_reg, frames_next;
    logic [FP_W-1:0]      frame_pixels_reg;
    logic [ADDR_W-1:0]    sweep_reg, sweep_next;

    logic [2:0]           item_act_reg, item_act_next;
    logic [IDX_W-1:0]     item_idx_reg, item_idx_next;
    logic [PIX_W-1:0]     item_pix_reg, item_pix_next;

    logic [DVD_W-1:0]     q_reg, q_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg, kind_next;
    logic [IDX_W-1:0]     ridx_reg, ridx_next;
    logic [DIFF_W-1:0]    diff_reg, diff_next;
    logic [COUNT_W-1:0]   fcount_reg, fcount_next;
    logic [WORD_W-1:0]    stored_reg, stored_next;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_W-1:0]    mem_wdata, mem_rdata;

    logic [FP_W-1:0]      frame_size;
    logic                 in_accept;
    logic                 idx_in_frame;
    logic                 out_free;

    logic                 exec_add;
    logic                 exec_last;
    logic [WORD_W-1:0]    exec_sum;
    logic signed [33:0]   exec_diff;
    logic [COUNT_W:0]     rem_shift;
    logic                 quot_bit;
    logic                 cfg_write;

    dfas_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_PIXELS)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_FRAME_PIXELS[2]) ?
                       {{(32 - FP_W){1'b0}}, frame_pixels_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
        end
        else if (cfg_write && paddr[2] == REG_FRAME_PIXELS[2])
        begin
            frame_pixels_reg <= pwdata[FP_W-1:0];
        end
    end

    always_comb
    begin
        if (frame_pixels_reg == '0)
        begin
            frame_size = FP_W'(1);
        end
        else if (frame_pixels_reg > SIZE_CAP)
        begin
            frame_size = SIZE_CAP;
        end
        else
        begin
            frame_size = frame_pixels_reg;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign idx_in_frame = ({1'b0, pixel_index} < frame_size);
    assign out_free     = !out_valid_reg || !out_stall;

    // Read-modify-write datapath for the item held in the execute state.
    assign exec_sum  = mem_rdata + {{(WORD_W - PIX_W){1'b0}}, item_pix_reg};
    assign exec_add  = (item_act_reg == ACT_PIXEL) && !mode_reg && (frames_reg != COUNT_MAX);
    assign exec_last = ({1'b0, item_idx_reg} == frame_size - FP_W'(1));
    assign exec_diff = $signed({2'b00, item_pix_reg, 8'b0}) - $signed({2'b00, mem_rdata});

    // One restoring division step; the remainder always stays below the count.
    assign rem_shift = {rem_reg, q_reg[DVD_W-1]};
    assign quot_bit  = (rem_shift >= {1'b0, frames_reg});

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        frames_next   = frames_reg;
        sweep_next    = sweep_reg;
        item_act_next = item_act_reg;
        item_idx_next = item_idx_reg;
        item_pix_next = item_pix_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next     = kind_reg;
        ridx_next     = ridx_reg;
        diff_next     = diff_reg;
        fcount_next   = fcount_reg;
        stored_next   = stored_reg;
        mem_we        = 1'b0;
        mem_waddr     = sweep_reg;
        mem_wdata     = '0;
        mem_raddr     = sweep_reg;

        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = ADDR_W'(pixel_index);
                if (in_accept)
                begin
                    case (action)
                        ACT_START:
                        begin
                            frames_next = '0;
                            mode_next   = 1'b0;
                            sweep_next  = '0;
                            state_next  = ST_CLEAR;
                        end
                        ACT_FINISH:
                        begin
                            if (!mode_reg)
                            begin
                                mode_next = 1'b1;
                                if (frames_reg != '0)
                                begin
                                    sweep_next = '0;
                                    state_next = ST_WALK_RD;
                                end
                            end
                        end
                        ACT_LOAD:
                        begin
                            if (idx_in_frame)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(pixel_index);
                                mem_wdata = {{(WORD_W - MASK_W){1'b0}}, mask_value};
                                mode_next = 1'b1;
                            end
                        end
                        ACT_PIXEL, ACT_READ:
                        begin
                            if (idx_in_frame)
                            begin
                                item_act_next = action;
                                item_idx_next = pixel_index;
                                item_pix_next = pixel_value;
                                state_next    = ST_EXEC;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EXEC:
            begin
                // Keep reading the same word so the data holds while stalled.
                mem_raddr = ADDR_W'(item_idx_reg);
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ridx_next      = item_idx_reg;
                    diff_next      = '0;
                    stored_next    = mem_rdata;
                    fcount_next    = frames_reg;
                    if (item_act_reg == ACT_READ)
                    begin
                        kind_next = KIND_READ;
                    end
                    else if (mode_reg)
                    begin
                        kind_next = KIND_DIFF;
                        if (exec_diff < DIFF_MIN)
                        begin
                            diff_next = DIFF_W'(DIFF_MIN);
                        end
                        else
                        begin
                            diff_next = DIFF_W'(exec_diff);
                        end
                    end
                    else
                    begin
                        kind_next = KIND_COLLECT;
                        if (exec_add)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = ADDR_W'(item_idx_reg);
                            mem_wdata   = exec_sum;
                            stored_next = exec_sum;
                            if (exec_last)
                            begin
                                frames_next = frames_reg + COUNT_W'(1);
                                fcount_next = frames_reg + COUNT_W'(1);
                            end
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '0;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_WALK_RD:
            begin
                state_next = ST_WALK_LD;
            end

            ST_WALK_LD:
            begin
                q_next       = {mem_rdata, 8'b0};
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_WALK_DIV;
            end

            ST_WALK_DIV:
            begin
                q_next       = {q_reg[DVD_W-2:0], quot_bit};
                rem_next     = quot_bit ? COUNT_W'(rem_shift - {1'b0, frames_reg}) :
                                          COUNT_W'(rem_shift);
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_WALK_WR;
                end
            end

            ST_WALK_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = q_reg[WORD_W-1:0];
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mode_reg      <= 1'b0;
            frames_reg    <= '0;
            sweep_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            frames_reg    <= frames_next;
            sweep_reg     <= sweep_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_act_reg <= item_act_next;
        item_idx_reg <= item_idx_next;
        item_pix_reg <= item_pix_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        kind_reg     <= kind_next;
        ridx_reg     <= ridx_next;
        diff_reg     <= diff_next;
        fcount_reg   <= fcount_next;
        stored_reg   <= stored_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign result_index = ridx_reg;
    assign difference   = $signed(diff_reg);
    assign frame_count  = fcount_reg;
    assign stored_value = stored_reg;

`ifndef SYNTH
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without an execute cycle");

    a_walk_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_RD) |-> mode_reg)
        else $error("mean walk running while still collecting");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (frames_reg != $past(frames_reg)) |->
        (frames_reg == $past(frames_reg) + COUNT_W'(1) || frames_reg == '0))
        else $error("frame count moved by other than one or a clear");

    a_idle_write_is_load: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_IDLE) |-> (in_accept && action == ACT_LOAD))
        else $error("store written in idle without a load");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_DIV) |-> (div_cnt_reg < DIV_CNT_W'(DIV_STEPS)))
        else $error("divider ran past its step count");
`endif

endmodule

`default_nettype wire
